>>> rtl/mvd_pkg.sv
// Shared types and constants for the MAVLink v2 frame decoder.
package mvd_pkg;

    localparam int MAX_PAYLOAD = 250;
    localparam int HEAD_BYTES  = 10;
    localparam int HEAD_W      = $clog2(HEAD_BYTES);
    localparam int LANES       = 4;
    localparam int SP_W        = 15;

    localparam logic [7:0]  START_BYTE = 8'hFD;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;   // 0x1021 reflected

    localparam logic [23:0] ID_MANUAL   = 24'd69;
    localparam logic [23:0] ID_RC       = 24'd70;
    localparam logic [23:0] ID_CMD_LONG = 24'd76;

    localparam logic [7:0] EXTRA_MANUAL   = 8'd243;
    localparam logic [7:0] EXTRA_RC       = 8'd124;
    localparam logic [7:0] EXTRA_CMD_LONG = 8'd152;

    localparam logic [15:0] CMD_ARM_DISARM = 16'd400;
    localparam logic [15:0] CMD_CALIBRATE  = 16'd241;
    localparam logic [15:0] RC_CENTRE      = 16'd1500;

    localparam logic [31:0] HALF_BITS = 32'h3F00_0000;   // 0.5f
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    // Action codes
    localparam logic [2:0] ACT_MANUAL  = 3'd0;
    localparam logic [2:0] ACT_RC      = 3'd1;
    localparam logic [2:0] ACT_ARM     = 3'd2;
    localparam logic [2:0] ACT_DISARM  = 3'd3;
    localparam logic [2:0] ACT_CAL     = 3'd4;

    // Scaled magnitude at which s1.14 saturates; scaling is mag * 16384 / 1000
    localparam logic [16:0] SCALE_LIMIT = 17'd1000;
    localparam logic [31:0] RECIP       = 32'd2147484;   // ceil(2^28 / 125)
    localparam int          RECIP_SHIFT = 17;
    localparam logic [SP_W-1:0] SAT_HI  = 15'h3FFF;
    localparam logic [SP_W-1:0] SAT_LO  = 15'h4000;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0]                action;
        logic [LANES-1:0][15:0]    raw;
    } ev_t;

    typedef struct packed {
        logic       neg;
        logic       sat_pos;
        logic       sat_neg;
        logic [9:0] mag;
    } lane_t;

endpackage

>>> rtl/mvd_parser.sv
// Frame parser: start hunt, header, payload head capture, CRC check, frame event.
module mvd_parser
    import mvd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       byte_ready,
    output logic       ev_valid,
    output ev_t        ev,
    input  logic       ev_ready
);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    phase_t                  phase_reg, phase_next;
    logic [7:0]              flen_reg, flen_next;
    logic [8:0]              idx_reg, idx_next;
    logic [15:0]             crc_reg, crc_next;
    logic [23:0]             msgid_reg, msgid_next;
    logic [7:0]              head_reg [HEAD_BYTES];
    logic [7:0]              head_next [HEAD_BYTES];
    logic [7:0]              crclow_reg, crclow_next;
    logic                    ev_valid_reg, ev_valid_next;
    ev_t                     ev_reg, ev_next;

    logic                    take;
    logic [8:0]              total;
    logic [8:0]              hofs;
    logic                    in_body, at_crc_lo, at_end;
    logic                    known, crc_ok, cmd_ok;
    logic [7:0]              extra;
    logic [15:0]             cmd;
    logic [31:0]             p1_bits;
    logic                    p1_above;

    assign byte_ready = !ev_valid_reg || ev_ready;
    assign take       = byte_valid && byte_ready;

    assign total     = {1'b0, flen_reg} + 9'd8;
    assign hofs      = idx_reg - 9'd8;
    assign in_body   = idx_reg < total;
    assign at_crc_lo = idx_reg == total;
    assign at_end    = !in_body && !at_crc_lo;

    assign cmd     = {head_reg[3], head_reg[2]};
    assign p1_bits = {head_reg[8], head_reg[7], head_reg[6], head_reg[5]};
    // float > 0.5 as a bit compare: positive, above 0.5, not NaN
    assign p1_above = !p1_bits[31] && (p1_bits > HALF_BITS) && (p1_bits <= INF_BITS);

    always_comb
    begin
        known = 1'b1;
        case (msgid_reg)
            ID_MANUAL:   extra = EXTRA_MANUAL;
            ID_RC:       extra = EXTRA_RC;
            ID_CMD_LONG: extra = EXTRA_CMD_LONG;
            default:
            begin
                extra = 8'h00;
                known = 1'b0;
            end
        endcase
    end

    assign crc_ok = crc_byte(crc_reg, extra) == {byte_data, crclow_reg};
    assign cmd_ok = (msgid_reg != ID_CMD_LONG) ||
                    (cmd inside {CMD_ARM_DISARM, CMD_CALIBRATE});

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT: if (byte_data == START_BYTE) phase_next = PH_LEN;
                PH_LEN:  phase_next = (byte_data > 8'(MAX_PAYLOAD)) ? PH_HUNT : PH_BODY;
                PH_BODY: if (at_end) phase_next = PH_HUNT;
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // Datapath and frame event
    always_comb
    begin
        flen_next   = flen_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        msgid_next  = msgid_reg;
        head_next   = head_reg;
        crclow_next = crclow_reg;
        ev_next     = ev_reg;
        ev_valid_next = ev_valid_reg && !ev_ready;

        if (take)
        begin
            ev_valid_next = 1'b0;
            case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_data == START_BYTE)
                    begin
                        for (int i = 0; i < HEAD_BYTES; i++)
                        begin
                            head_next[i] = 8'h00;
                        end
                        crc_next = CRC_INIT;
                        idx_next = 9'd0;
                    end
                end
                PH_LEN:
                begin
                    flen_next = byte_data;
                    if (byte_data <= 8'(MAX_PAYLOAD))
                    begin
                        crc_next   = crc_byte(crc_reg, byte_data);
                        idx_next   = 9'd0;
                        msgid_next = 24'd0;
                    end
                end
                PH_BODY:
                begin
                    if (in_body)
                    begin
                        crc_next = crc_byte(crc_reg, byte_data);
                        case (idx_reg)
                            9'd5:    msgid_next[7:0]   = byte_data;
                            9'd6:    msgid_next[15:8]  = byte_data;
                            9'd7:    msgid_next[23:16] = byte_data;
                            default: ;
                        endcase
                        if (idx_reg >= 9'd8 && hofs < 9'(HEAD_BYTES))
                        begin
                            for (int i = 0; i < HEAD_BYTES; i++)
                            begin
                                if (hofs[HEAD_W-1:0] == HEAD_W'(i))
                                    head_next[i] = byte_data;
                            end
                        end
                        idx_next = idx_reg + 9'd1;
                    end
                    else if (at_crc_lo)
                    begin
                        crclow_next = byte_data;
                        idx_next    = idx_reg + 9'd1;
                    end
                    else
                    begin
                        idx_next      = 9'd0;
                        ev_valid_next = known && crc_ok && cmd_ok;
                        ev_next.raw   = '0;
                        if (msgid_reg == ID_MANUAL)
                        begin
                            ev_next.action = ACT_MANUAL;
                            ev_next.raw[0] = {head_reg[1], head_reg[0]};
                            ev_next.raw[1] = {head_reg[3], head_reg[2]};
                            ev_next.raw[2] = {head_reg[5], head_reg[4]};
                            ev_next.raw[3] = {head_reg[7], head_reg[6]};
                        end
                        else if (msgid_reg == ID_RC)
                        begin
                            ev_next.action = ACT_RC;
                            ev_next.raw[0] = {head_reg[3], head_reg[2]};
                            ev_next.raw[1] = {head_reg[5], head_reg[4]};
                            ev_next.raw[2] = {head_reg[7], head_reg[6]};
                            ev_next.raw[3] = {head_reg[9], head_reg[8]};
                        end
                        else if (cmd == CMD_CALIBRATE)
                            ev_next.action = ACT_CAL;
                        else
                            ev_next.action = p1_above ? ACT_ARM : ACT_DISARM;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            flen_reg     <= 8'd0;
            idx_reg      <= 9'd0;
            crc_reg      <= CRC_INIT;
            msgid_reg    <= 24'd0;
            crclow_reg   <= 8'd0;
            ev_valid_reg <= 1'b0;
            for (int i = 0; i < HEAD_BYTES; i++)
            begin
                head_reg[i] <= 8'h00;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            flen_reg     <= flen_next;
            idx_reg      <= idx_next;
            crc_reg      <= crc_next;
            msgid_reg    <= msgid_next;
            crclow_reg   <= crclow_next;
            ev_valid_reg <= ev_valid_next;
            head_reg     <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

>>> rtl/mvd_convert.sv
// Setpoint conversion: raw sticks or RC channels to clamped s1.14, two stages.
module mvd_convert
    import mvd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ev_valid,
    input  ev_t                         ev,
    output logic                        ev_ready,
    output logic                        out_valid,
    output logic [2:0]                  out_action,
    output logic [LANES-1:0][SP_W-1:0]  out_sp,
    input  logic                        out_ready
);

    logic                        s1_valid_reg, s1_valid_next;
    logic [2:0]                  s1_action_reg;
    lane_t                       s1_lane_reg [LANES];
    lane_t                       s1_lane_next [LANES];
    logic                        o_valid_reg, o_valid_next;
    logic [2:0]                  o_action_reg;
    logic [LANES-1:0][SP_W-1:0]  o_sp_reg, o_sp_next;

    logic                        o_free, s1_free;

    assign o_free   = !o_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || o_free;
    assign ev_ready = s1_free;

    // Stage 1: sign, magnitude scaled to the manual range, saturation flags
    always_comb
    begin
        logic signed [17:0] d;
        logic [17:0]        dm;
        logic [16:0]        m;
        logic               n;
        for (int k = 0; k < LANES; k++)
        begin
            d  = $signed({2'b00, ev.raw[k]}) - $signed({2'b00, RC_CENTRE});
            dm = d[17] ? (18'd0 - d) : d;
            if (ev.action == ACT_RC)
            begin
                n = d[17];
                m = {dm[15:0], 1'b0};   // rc scale is twice the stick scale
            end
            else
            begin
                n = ev.raw[k][15];
                m = n ? (17'h1_0000 - {1'b0, ev.raw[k]}) : {1'b0, ev.raw[k]};
            end
            s1_lane_next[k].neg     = n;
            s1_lane_next[k].sat_pos = !n && (m >= SCALE_LIMIT);
            s1_lane_next[k].sat_neg = n && (m > SCALE_LIMIT);
            s1_lane_next[k].mag     = m[9:0];
        end
    end

    // Stage 2: reciprocal multiply, sign and clamp
    always_comb
    begin
        logic [31:0]     prod;
        logic [SP_W-1:0] q;
        for (int k = 0; k < LANES; k++)
        begin
            prod = 32'(s1_lane_reg[k].mag) * RECIP;
            q    = prod[31:RECIP_SHIFT];
            if (s1_lane_reg[k].sat_pos)
                o_sp_next[k] = SAT_HI;
            else if (s1_lane_reg[k].sat_neg)
                o_sp_next[k] = SAT_LO;
            else if (s1_lane_reg[k].neg)
                o_sp_next[k] = SP_W'(0) - q;
            else
                o_sp_next[k] = q;
        end
    end

    assign s1_valid_next = s1_free ? ev_valid : s1_valid_reg;
    assign o_valid_next  = o_free ? s1_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && ev_valid)
        begin
            s1_action_reg <= ev.action;
            s1_lane_reg   <= s1_lane_next;
        end
        if (o_free && s1_valid_reg)
        begin
            o_action_reg <= s1_action_reg;
            o_sp_reg     <= o_sp_next;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_action = o_action_reg;
    assign out_sp     = o_sp_reg;

endmodule

>>> rtl/mavlink_v2_frame_decoder.sv
// MAVLink v2 receive decoder top level: input register, parser and setpoint conversion.
//
// Takes one received byte per beat and accepts a byte every cycle while the
// output side keeps up. Frames start at 0xFD; lengths above 250 abort. The
// CRC-16/MCRF4XX runs from the length byte on, closed with the message's
// extra seed byte; unknown IDs and bad CRCs are dropped silently. MANUAL_CONTROL
// and RC_OVERRIDE give four clamped s1.14 setpoints; COMMAND_LONG gives arm,
// disarm or calibrate with zero setpoints, and other commands are dropped. After
// the last CRC byte is taken, a result beat passes through the input register,
// the parser's event register (byte CRC and frame check) and the first
// conversion stage, and then sits in the output register until taken. Each
// stage holds one beat and frees itself as soon as the next one can take it.
module mavlink_v2_frame_decoder
    import mvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [14:0] surge, [29:15] sway, [44:30] heave,
                                    // [59:45] yaw_rate, [63:60] zero
    output logic [2:0]  m_tuser     // [2:0] action
);

    logic                        in_valid_reg, in_valid_next;
    logic [7:0]                  in_data_reg;
    logic                        byte_ready;
    logic                        ev_valid, ev_ready;
    ev_t                         ev;
    logic [LANES-1:0][SP_W-1:0]  sp;

    assign s_tready      = !in_valid_reg || byte_ready;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
    end

    mvd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid_reg),
        .byte_data  (in_data_reg),
        .byte_ready (byte_ready),
        .ev_valid   (ev_valid),
        .ev         (ev),
        .ev_ready   (ev_ready)
    );

    mvd_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev_valid   (ev_valid),
        .ev         (ev),
        .ev_ready   (ev_ready),
        .out_valid  (m_tvalid),
        .out_action (m_tuser),
        .out_sp     (sp),
        .out_ready  (m_tready)
    );

    assign m_tdata = {4'b0000, sp[3], sp[2], sp[1], sp[0]};

    // Command results carry no setpoints
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ACT_ARM || m_tuser == ACT_DISARM || m_tuser == ACT_CAL)
        |-> m_tdata == 64'd0)
        else $error("command result with non-zero setpoints");

    // Only defined action codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ACT_CAL)
        else $error("undefined action code");

    // A held input beat is never dropped while the parser stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !byte_ready |=> in_valid_reg && $stable(in_data_reg))
        else $error("input beat lost under stall");

    // An empty input register always accepts
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input refused with empty register");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the MAVLink v2 frame decoder: byte beats in, setpoint/command beats out.
module tb_top
    import mvd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]                 action;
        logic [LANES-1:0][SP_W-1:0] sp;     // 0 surge, 1 sway, 2 heave, 3 yaw_rate
    } beat_t;

    // One directed frame: message id, length, five LE words over payload bytes 0..9,
    // param1 bits (COMMAND_LONG only), then the hand-worked result where there is one.
    typedef struct packed {
        logic [23:0]     msg_id;
        logic [7:0]      len;
        logic [15:0]     w0, w1, w2, w3, w4;
        logic [31:0]     param;
        logic            bad_crc;
        logic            typed;
        logic [2:0]      act;
        logic [SP_W-1:0] surge, sway, heave, yaw;
    } frame_row_t;

    localparam logic [23:0] ID_UNUSED   = 24'd0;
    localparam logic [23:0] ID_FAR      = ID_MANUAL | 24'h01_0000;  // low byte aliases
    localparam logic [15:0] CMD_UNKNOWN = 16'd123;
    localparam longint      SP_MAX      = 16383;
    localparam longint      SP_MIN      = -16384;

    localparam int          PHASES           = 4;
    localparam int          ITEMS_PER_PHASE  = 310;
    localparam int          SEND_IDLE [PHASES] = '{0, 86, 0, 34};
    localparam int          RECV_STALL [PHASES] = '{0, 0, 86, 34};

    localparam frame_row_t DIRECTED [21] = '{
        '{ID_MANUAL, 8'd8, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, 1'b1,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_MANUAL, 8'd8, 16'd1000, 16'hFC18, 16'h7FFF, 16'h8000, 16'd0, 32'd0, 1'b0, 1'b1,
          ACT_MANUAL, SAT_HI, SAT_LO, SAT_HI, SAT_LO},
        '{ID_MANUAL, 8'd3, 16'd500, 16'h1234, 16'h5678, 16'h9ABC, 16'd0, 32'd0, 1'b0, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_MANUAL, 8'd250, 16'd61, 16'hFFC3, 16'd999, 16'hFC19, 16'd0, 32'd0, 1'b0, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_MANUAL, 8'd0, 16'd700, 16'd700, 16'd700, 16'd700, 16'd0, 32'd0, 1'b0, 1'b1,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_RC, 8'd10, 16'd0, 16'd1500, 16'd1500, 16'd1500, 16'd1500, 32'd0, 1'b0, 1'b1,
          ACT_RC, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_RC, 8'd10, 16'hBEEF, 16'd0, 16'hFFFF, 16'd1000, 16'd2000, 32'd0, 1'b0, 1'b1,
          ACT_RC, SAT_LO, SAT_HI, SAT_LO, SAT_HI},
        '{ID_CMD_LONG, 8'd33, 16'd0, CMD_ARM_DISARM, 16'd0, 16'd0, 16'd0, 32'h3F80_0000,
          1'b0, 1'b1, ACT_ARM, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_CMD_LONG, 8'd10, 16'd0, CMD_ARM_DISARM, 16'd0, 16'd0, 16'd0, HALF_BITS,
          1'b0, 1'b1, ACT_DISARM, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_CMD_LONG, 8'd10, 16'd0, CMD_ARM_DISARM, 16'd0, 16'd0, 16'd0, INF_BITS,
          1'b0, 1'b1, ACT_ARM, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_CMD_LONG, 8'd10, 16'd0, CMD_ARM_DISARM, 16'd0, 16'd0, 16'd0, 32'h7F80_0001,
          1'b0, 1'b1, ACT_DISARM, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_CMD_LONG, 8'd10, 16'd0, CMD_ARM_DISARM, 16'd0, 16'd0, 16'd0, 32'hBF80_0000,
          1'b0, 1'b1, ACT_DISARM, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_CMD_LONG, 8'd10, 16'd0, CMD_CALIBRATE, 16'd0, 16'd0, 16'd0, 32'd0,
          1'b0, 1'b1, ACT_CAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_CMD_LONG, 8'd10, 16'd0, CMD_UNKNOWN, 16'd0, 16'd0, 16'd0, 32'h3F80_0000,
          1'b0, 1'b0, ACT_CAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_CMD_LONG, 8'd4, 16'd0, CMD_ARM_DISARM, 16'd0, 16'd0, 16'd0, 32'h3F80_0000,
          1'b0, 1'b1, ACT_DISARM, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_UNUSED, 8'd8, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 32'd0, 1'b0, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_FAR, 8'd8, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 32'd0, 1'b0, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_MANUAL, 8'd8, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 32'd0, 1'b1, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_MANUAL, 8'd251, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_MANUAL, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0},
        '{ID_MANUAL, 8'd11, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 32'd0, 1'b0, 1'b0,
          ACT_MANUAL, 15'd0, 15'd0, 15'd0, 15'd0}
    };

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;   // [14:0] surge, [29:15] sway, [44:30] heave, [59:45] yaw_rate
    logic [2:0]  m_tuser;   // [2:0] action

    mavlink_v2_frame_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Decoder mirror
    phase_t      rx_phase;
    logic [7:0]  rx_len;
    logic [8:0]  rx_index;
    logic [15:0] rx_crc;
    logic [23:0] rx_msg_id;
    logic [7:0]  rx_head [HEAD_BYTES];
    logic [7:0]  rx_crc_lo;

    beat_t       expected_beats [$];
    logic [7:0]  frame_bytes [$];
    logic [7:0]  payload [MAX_PAYLOAD];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatches     = 0;
    int          frame_items    = 0;
    string       lane_name [LANES] = '{"surge", "sway", "heave", "yaw_rate"};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        return v;
    endfunction

    function automatic logic [SP_W-1:0] saturate_sp(input longint v);
        if (v > SP_MAX)
            return SAT_HI;
        if (v < SP_MIN)
            return SAT_LO;
        return v[SP_W-1:0];
    endfunction

    function automatic logic [SP_W-1:0] stick_to_sp(input logic [15:0] raw);
        longint s;
        s = longint'($signed(raw));
        return saturate_sp((s * 16384) / 1000);
    endfunction

    function automatic logic [SP_W-1:0] rc_to_sp(input logic [15:0] raw);
        longint s;
        s = longint'(raw) - longint'(RC_CENTRE);
        return saturate_sp((s * 32768) / 1000);
    endfunction

    // Advances the mirror by one byte; returns 1 when that byte completes a result.
    function automatic bit decode_byte(input logic [7:0] c, output beat_t r);
        logic [8:0]  total;
        logic [7:0]  extra;
        logic [15:0] cmd;
        logic [31:0] bits;
        bit          known;
        r = '0;
        decode_byte = 1'b0;
        case (rx_phase)
            PH_HUNT:
            begin
                if (c == START_BYTE)
                begin
                    foreach (rx_head[i])
                        rx_head[i] = 8'h00;
                    rx_crc   = CRC_INIT;
                    rx_index = '0;
                    rx_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                rx_len = c;
                if (c > MAX_PAYLOAD)
                    rx_phase = PH_HUNT;     // aborted, and not a start byte either
                else
                begin
                    rx_crc    = crc_step(rx_crc, c);
                    rx_index  = '0;
                    rx_msg_id = '0;
                    rx_phase  = PH_BODY;
                end
            end
            default:
            begin
                total = {1'b0, rx_len} + 9'd8;
                if (rx_index < total)
                begin
                    rx_crc = crc_step(rx_crc, c);
                    if (rx_index >= 5 && rx_index < 8)
                        rx_msg_id[8*(rx_index-5) +: 8] = c;
                    else if (rx_index >= 8 && rx_index - 8 < HEAD_BYTES)
                        rx_head[rx_index-8] = c;
                    rx_index++;
                end
                else if (rx_index == total)
                begin
                    rx_crc_lo = c;
                    rx_index++;
                end
                else
                begin
                    rx_phase = PH_HUNT;
                    rx_index = '0;
                    known    = 1'b1;
                    case (rx_msg_id)
                        ID_MANUAL:   extra = EXTRA_MANUAL;
                        ID_RC:       extra = EXTRA_RC;
                        ID_CMD_LONG: extra = EXTRA_CMD_LONG;
                        default:
                        begin
                            extra = 8'h00;
                            known = 1'b0;
                        end
                    endcase
                    if (known && crc_step(rx_crc, extra) == {c, rx_crc_lo})
                    begin
                        if (rx_msg_id == ID_MANUAL)
                        begin
                            r.action = ACT_MANUAL;
                            for (int k = 0; k < LANES; k++)
                                r.sp[k] = stick_to_sp({rx_head[2*k+1], rx_head[2*k]});
                            decode_byte = 1'b1;
                        end
                        else if (rx_msg_id == ID_RC)
                        begin
                            r.action = ACT_RC;
                            for (int k = 0; k < LANES; k++)
                                r.sp[k] = rc_to_sp({rx_head[2*k+3], rx_head[2*k+2]});
                            decode_byte = 1'b1;
                        end
                        else
                        begin
                            cmd  = {rx_head[3], rx_head[2]};
                            bits = {rx_head[8], rx_head[7], rx_head[6], rx_head[5]};
                            if (cmd == CMD_ARM_DISARM)
                            begin
                                // param1 > 0.5 as a bit compare; NaN falls through to disarm
                                r.action = (!bits[31] && bits > HALF_BITS && bits <= INF_BITS)
                                           ? ACT_ARM : ACT_DISARM;
                                decode_byte = 1'b1;
                            end
                            else if (cmd == CMD_CALIBRATE)
                            begin
                                r.action = ACT_CAL;
                                decode_byte = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic void put_word(input int at, input logic [15:0] w);
        payload[at]   = w[7:0];
        payload[at+1] = w[15:8];
    endfunction

    function automatic void put_param(input logic [31:0] bits);
        for (int k = 0; k < 4; k++)
            payload[5+k] = bits[8*k +: 8];
    endfunction

    // Frames the first len payload bytes; an over-long length gives start and length only.
    task automatic build_frame(input logic [23:0] id, input int len, input bit bad_crc);
        logic [15:0] crc;
        logic [7:0]  b;
        logic [7:0]  extra;
        frame_bytes.delete();
        frame_bytes.push_back(START_BYTE);
        frame_bytes.push_back(8'(len));
        if (len > MAX_PAYLOAD)
            return;
        crc = crc_step(CRC_INIT, 8'(len));
        for (int i = 0; i < 8; i++)
        begin
            b = (i < 5) ? 8'($urandom) : id[8*(i-5) +: 8];
            frame_bytes.push_back(b);
            crc = crc_step(crc, b);
        end
        for (int i = 0; i < len; i++)
        begin
            frame_bytes.push_back(payload[i]);
            crc = crc_step(crc, payload[i]);
        end
        case (id)
            ID_MANUAL:   extra = EXTRA_MANUAL;
            ID_RC:       extra = EXTRA_RC;
            ID_CMD_LONG: extra = EXTRA_CMD_LONG;
            default:     extra = 8'($urandom);
        endcase
        crc = crc_step(crc, extra);
        if (bad_crc)
            crc ^= 16'd1 << $urandom_range(15);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit use_want, input beat_t want);
        beat_t pred;
        bit    hit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hit = decode_byte(b, pred);
        if (use_want)
        begin
            expected_beats.push_back(want);
        end
        else if (hit)
        begin
            expected_beats.push_back(pred);
        end
    endtask

    task automatic send_frame(input bit typed, input beat_t want);
        frame_items += frame_bytes.size();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], typed && i == frame_bytes.size() - 1, want);
    endtask

    function automatic logic [15:0] stick_word();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'(998 + $urandom_range(4));     // around the clamp edge
            3:       return 16'(-1002 + $urandom_range(4));
            4, 5:    return 16'($urandom_range(2200) - 1100);
            6:       return 16'($urandom_range(120) - 60);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rc_word();
        case ($urandom_range(9))
            0:          return 16'h0000;
            1:          return 16'hFFFF;
            2:          return 16'(1498 + $urandom_range(4));
            3, 4, 5, 6: return 16'($urandom_range(2100, 900));
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] param_word();
        case ($urandom_range(11))
            0:       return HALF_BITS;
            1:       return HALF_BITS + 32'd1;
            2:       return HALF_BITS - 32'd1;
            3:       return INF_BITS;
            4:       return INF_BITS + 32'd1;
            5:       return 32'h3F80_0000;
            6:       return {1'b1, 31'($urandom)};
            7:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed frames with random content; the rest noise, bad CRCs,
    // unknown IDs, over-long lengths and frames cut short.
    task automatic random_frame();
        int          pick;
        int          len;
        int          u;
        int          cut;
        logic [23:0] id;
        bit          bad_crc;
        logic [15:0] cmd;
        bad_crc = 1'b0;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(4, 1))
                send_byte(8'($urandom), 1'b0, '0);
        pick = $urandom_range(99);
        case ($urandom_range(2))
            0:       id = ID_MANUAL;
            1:       id = ID_RC;
            default: id = ID_CMD_LONG;
        endcase
        u = $urandom_range(99);
        if (u < 60)
            len = $urandom_range(12);
        else if (u < 85)
            len = $urandom_range(40, 13);
        else if (u < 98)
            len = $urandom_range(120, 41);
        else
            len = $urandom_range(MAX_PAYLOAD, 121);
        foreach (payload[k])
            payload[k] = 8'($urandom);
        case (id)
            ID_MANUAL:
                for (int k = 0; k < LANES; k++)
                    put_word(2 * k, stick_word());
            ID_RC:
                for (int k = 0; k < LANES; k++)
                    put_word(2 * k + 2, rc_word());
            default:
            begin
                u = $urandom_range(99);
                cmd = (u < 45) ? CMD_ARM_DISARM : (u < 80) ? CMD_CALIBRATE : 16'($urandom);
                put_word(2, cmd);
                put_param(param_word());
            end
        endcase
        if (pick >= 78 && pick < 84)
            bad_crc = 1'b1;
        else if (pick >= 84 && pick < 90)
            id = ($urandom_range(3) == 0) ? 24'($urandom) : id ^ (24'd1 << $urandom_range(23));
        else if (pick >= 90 && pick < 95)
            len = $urandom_range(255, MAX_PAYLOAD + 1);
        build_frame(id, len, bad_crc);
        if (pick >= 95)
        begin
            cut = $urandom_range(frame_bytes.size() - 1, 2);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        send_frame(1'b0, '0);
    endtask

    always @(posedge clk)
    begin : beat_monitor
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", 64'({m_tuser, m_tdata[59:0]}), '0);
            else
            begin
                want = expected_beats.pop_front();
                if (m_tuser !== want.action)
                    report_mismatch("action", 64'(m_tuser), 64'(want.action));
                for (int k = 0; k < LANES; k++)
                    if (m_tdata[SP_W*k +: SP_W] !== want.sp[k])
                        report_mismatch(lane_name[k], 64'(m_tdata[SP_W*k +: SP_W]),
                                        64'(want.sp[k]));
                if (m_tdata[63:60] !== 4'h0)
                    report_mismatch("tdata padding", 64'(m_tdata[63:60]), '0);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : stimulus
        frame_row_t row;
        beat_t      want;
        int         target;
        rx_phase  = PH_HUNT;
        rx_len    = '0;
        rx_index  = '0;
        rx_crc    = CRC_INIT;
        rx_msg_id = '0;
        rx_crc_lo = '0;
        foreach (rx_head[i])
            rx_head[i] = 8'h00;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            for (int k = 0; k < MAX_PAYLOAD; k++)
                payload[k] = 8'(k * 37 + 11);
            put_word(0, row.w0);
            put_word(2, row.w1);
            put_word(4, row.w2);
            put_word(6, row.w3);
            put_word(8, row.w4);
            if (row.msg_id == ID_CMD_LONG)
                put_param(row.param);
            want.action = row.act;
            want.sp[0]  = row.surge;
            want.sp[1]  = row.sway;
            want.sp[2]  = row.heave;
            want.sp[3]  = row.yaw;
            build_frame(row.msg_id, int'(row.len), row.bad_crc);
            send_frame(row.typed, want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            target = frame_items + ITEMS_PER_PHASE;
            while (frame_items < target)
                random_frame();
        end
        s_tvalid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        // then wait on to catch a stray beat behind the last one
        repeat (24) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
